// ===== rtl/bts_pkg.sv =====
package bts_pkg;

  // default sizes
  localparam int TRAIL_DEPTH_DEF = 64;
  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int DATA_WIDTH_DEF  = 32;

  // field widths fixed by the interface
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W  = 7;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_BACKUP     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LEVEL_UP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LEVEL_DOWN = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic                push;        // write new entry at top
    logic                push_marker; // entry is a level marker
    logic                walk_start;  // read entry below top
    logic                walk_step;   // keep read entry as pending, read next one down
    logic                walk_end;    // marker reached: pop it, lower level
    logic                walk_drop;   // bottom reached with no marker: trail empty
    logic                out_en;      // load result registers
    logic                out_write;   // result carries the pending restore write
    logic                out_last;
    logic                out_dec;     // report level minus one
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic level_zero;
    logic rd_marker;
    logic rd_bottom;
    logic pend_valid;
  } sts_t;

endpackage

// ===== rtl/bts_datapath.sv =====
module bts_datapath #(
  parameter int TRAIL_DEPTH = bts_pkg::TRAIL_DEPTH_DEF,
  parameter int ADDR_WIDTH  = bts_pkg::ADDR_WIDTH_DEF,
  parameter int DATA_WIDTH  = bts_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bts_pkg::cmd_t                    cmd_i,
  output bts_pkg::sts_t                    sts_o,
  input  logic [ADDR_WIDTH-1:0]            target_address_i,
  input  logic signed [DATA_WIDTH-1:0]     saved_value_i,
  output logic                             result_valid_o,
  output logic                             write_valid_o,
  output logic [ADDR_WIDTH-1:0]            write_address_o,
  output logic signed [DATA_WIDTH-1:0]     write_value_o,
  output logic [bts_pkg::LEVEL_W-1:0]      depth_level_o,
  output logic [bts_pkg::STATUS_W-1:0]     status_o,
  output logic                             last_o
);

  localparam int IdxW  = $clog2(TRAIL_DEPTH);
  localparam int PtrW  = $clog2(TRAIL_DEPTH + 1);
  localparam int WordW = ADDR_WIDTH + DATA_WIDTH + 1;
  localparam int LvlW  = bts_pkg::LEVEL_W;
  localparam int StW   = bts_pkg::STATUS_W;

  // entry word: {marker, address, value}
  logic [WordW-1:0] trail_mem [TRAIL_DEPTH];
  logic [WordW-1:0] rdata_q;
  logic [WordW-1:0] wdata;
  logic [IdxW-1:0]  raddr;
  logic             rd_en;

  logic [PtrW-1:0]  top_q, top_d, top_m1;
  logic [PtrW-1:0]  level_q, level_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic             pend_valid_q, pend_valid_d;
  logic [WordW-1:0] pend_q;

  logic                        out_valid_q;
  logic                        wr_valid_q;
  logic [ADDR_WIDTH-1:0]       wr_addr_q;
  logic [DATA_WIDTH-1:0]       wr_value_q;
  logic [LvlW-1:0]             depth_q;
  logic [StW-1:0]              status_q;
  logic                        last_q;
  logic [PtrW-1:0]             level_out;

  assign top_m1 = top_q - PtrW'(1);
  assign wdata  = cmd_i.push_marker ? {1'b1, {(ADDR_WIDTH + DATA_WIDTH){1'b0}}}
                                    : {1'b0, target_address_i, $unsigned(saved_value_i)};
  assign raddr  = cmd_i.walk_start ? top_m1[IdxW-1:0] : rd_ptr_q - IdxW'(1);
  assign rd_en  = cmd_i.walk_start | cmd_i.walk_step;

  // trail memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      trail_mem[top_q[IdxW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= trail_mem[raddr];
    end
  end

  always_comb begin
    top_d = top_q;
    if (cmd_i.push) begin
      top_d = top_q + PtrW'(1);
    end else if (cmd_i.walk_end) begin
      top_d = PtrW'(rd_ptr_q);
    end else if (cmd_i.walk_drop) begin
      top_d = '0;
    end
  end

  always_comb begin
    level_d = level_q;
    if (cmd_i.push && cmd_i.push_marker) begin
      level_d = level_q + PtrW'(1);
    end else if (cmd_i.walk_end) begin
      level_d = level_q - PtrW'(1);
    end
  end

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.walk_start) begin
      rd_ptr_d = top_m1[IdxW-1:0];
    end else if (cmd_i.walk_step) begin
      rd_ptr_d = rd_ptr_q - IdxW'(1);
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.walk_start || cmd_i.walk_end || cmd_i.walk_drop) begin
      pend_valid_d = 1'b0;
    end else if (cmd_i.walk_step) begin
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q        <= '0;
      level_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      top_q        <= top_d;
      level_q      <= level_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= cmd_i.out_en;
    end
  end

  assign level_out = cmd_i.out_dec ? level_q - PtrW'(1) : level_d;

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    if (cmd_i.walk_step) begin
      pend_q <= rdata_q;
    end
    if (cmd_i.out_en) begin
      wr_valid_q <= cmd_i.out_write;
      wr_addr_q  <= cmd_i.out_write ? pend_q[WordW-2 -: ADDR_WIDTH] : '0;
      wr_value_q <= cmd_i.out_write ? pend_q[DATA_WIDTH-1:0] : '0;
      depth_q    <= LvlW'(level_out);
      status_q   <= cmd_i.out_status;
      last_q     <= cmd_i.out_last;
    end
  end

  assign sts_o.full       = (top_q == PtrW'(TRAIL_DEPTH));
  assign sts_o.level_zero = (level_q == '0);
  assign sts_o.rd_marker  = rdata_q[WordW-1];
  assign sts_o.rd_bottom  = (rd_ptr_q == '0);
  assign sts_o.pend_valid = pend_valid_q;

  assign result_valid_o  = out_valid_q;
  assign write_valid_o   = wr_valid_q;
  assign write_address_o = wr_addr_q;
  assign write_value_o   = $signed(wr_value_q);
  assign depth_level_o   = depth_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

  // a push never lands on a full trail
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !sts_o.full)
    else $error("push issued on full trail");

  // every open level owns a marker on the trail
  a_level_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= top_q)
    else $error("level count exceeds trail occupancy");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= PtrW'(TRAIL_DEPTH))
    else $error("top pointer beyond trail depth");

  // a restore write only comes from a pending popped entry
  a_write_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_en && cmd_i.out_write |-> pend_valid_q)
    else $error("restore write without pending entry");

endmodule

// ===== rtl/bts_ctrl.sv =====
module bts_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bts_pkg::OPCODE_W-1:0]  opcode_i,
  input  bts_pkg::sts_t                 sts_i,
  output bts_pkg::cmd_t                 cmd_o,
  output logic                          busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_status = bts_pkg::STATUS_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.out_en   = 1'b1;
          cmd_o.out_last = 1'b1;
          case (opcode_i)
            bts_pkg::OP_BACKUP, bts_pkg::OP_LEVEL_UP: begin
              if (sts_i.full) begin
                cmd_o.out_status = bts_pkg::STATUS_OVERFLOW;
              end else begin
                cmd_o.push        = 1'b1;
                cmd_o.push_marker = (opcode_i == bts_pkg::OP_LEVEL_UP);
              end
            end
            bts_pkg::OP_LEVEL_DOWN: begin
              if (sts_i.level_zero) begin
                cmd_o.out_status = bts_pkg::STATUS_UNDERFLOW;
              end else begin
                cmd_o.out_en     = 1'b0;
                cmd_o.out_last   = 1'b0;
                cmd_o.walk_start = 1'b1;
                state_d          = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cmd_o.out_dec = 1'b1;
        if (sts_i.rd_marker) begin
          cmd_o.walk_end  = 1'b1;
          cmd_o.out_en    = 1'b1;
          cmd_o.out_write = sts_i.pend_valid;
          cmd_o.out_last  = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.walk_step = 1'b1;
          cmd_o.out_en    = sts_i.pend_valid;
          cmd_o.out_write = sts_i.pend_valid;
          if (sts_i.rd_bottom) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cmd_o.walk_drop  = 1'b1;
        cmd_o.out_en     = 1'b1;
        cmd_o.out_write  = 1'b1;
        cmd_o.out_last   = 1'b1;
        cmd_o.out_status = bts_pkg::STATUS_UNDERFLOW;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // a walk only starts from idle on an accepted level-down
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i) && $past(opcode_i) == bts_pkg::OP_LEVEL_DOWN)
    else $error("walk entered without level-down");

  // leaving the walk always closes the item with a last result
  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && state_d == S_IDLE |-> cmd_o.out_en && cmd_o.out_last)
    else $error("walk ended without last result");

  a_one_walk_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push, cmd_o.walk_start, cmd_o.walk_step, cmd_o.walk_end,
              cmd_o.walk_drop}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/backtrack_trail_stack.sv =====
// backtracking trail stack: an undo log for depth-first search. start_i with
// busy_o low transfers one item. backup (opcode 0) pushes an address and its
// old value; level-up (opcode 1) pushes a level marker and raises the level;
// level-down (opcode 2) pops entries newest first down to the latest marker,
// giving one restore write per popped entry, then pops the marker. every item
// yields at least one result, shown for exactly one cycle with result_valid_o
// and last_o set on its final one; the receiver cannot stall, so it must take
// every result as it appears. a push into a full trail is refused with
// overflow status, a level-down with level zero gives underflow. backup,
// level-up and opcode 3 finish in the cycle of their transfer (the result
// shows in the following cycle) and busy_o stays low, so such items may
// follow every cycle. a level-down keeps busy_o high after its transfer
// until the walk reaches its marker: the trail memory has one registered
// read port and the walk reads one entry per cycle, one entry ahead of the
// result, so it knows which restore write is the last. restore results
// follow one per cycle. no clearing pass is needed after reset.
module backtrack_trail_stack #(
  parameter int TRAIL_DEPTH = bts_pkg::TRAIL_DEPTH_DEF,
  parameter int ADDR_WIDTH  = bts_pkg::ADDR_WIDTH_DEF,
  parameter int DATA_WIDTH  = bts_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bts_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [ADDR_WIDTH-1:0]         target_address_i,
  input  logic signed [DATA_WIDTH-1:0]  saved_value_i,
  // result side
  output logic                          result_valid_o,
  output logic                          write_valid_o,
  output logic [ADDR_WIDTH-1:0]         write_address_o,
  output logic signed [DATA_WIDTH-1:0]  write_value_o,
  output logic [bts_pkg::LEVEL_W-1:0]   depth_level_o,
  output logic [bts_pkg::STATUS_W-1:0]  status_o,
  output logic                          last_o
);

  bts_pkg::cmd_t cmd;   // sequencing commands
  bts_pkg::sts_t sts;   // trail status back to the controller

  // controller: idle / walk / drain sequencing of each item
  bts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath: trail memory, top pointer, level count, pending entry, result regs
  bts_datapath #(
    .TRAIL_DEPTH (TRAIL_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .target_address_i (target_address_i),
    .saved_value_i    (saved_value_i),
    .result_valid_o   (result_valid_o),
    .write_valid_o    (write_valid_o),
    .write_address_o  (write_address_o),
    .write_value_o    (write_value_o),
    .depth_level_o    (depth_level_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
